[hdl/ptpmd_pkg.sv]
`timescale 1ns / 1ps
package ptpmd_pkg;

   localparam int TS_W       = 63;
   localparam int DATA_W     = 64;
   localparam int WIN_W      = 32;
   localparam int GAIN_W     = 17;
   localparam int GAIN_FRAC  = 16;
   localparam int PROD_W     = DATA_W + GAIN_W + 1;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = ((4 * TS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 5 * DATA_W;

   localparam logic [DATA_W-1:0] NO_SAMPLE = 64'd1000000000;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_STEP = 2'd1;
   localparam logic [1:0] KIND_GAIN = 2'd2;

   localparam logic [2:0] REG_WIN_LOW  = 3'd0;
   localparam logic [2:0] REG_WIN_HIGH = 3'd1;
   localparam logic [2:0] REG_STEP     = 3'd2;
   localparam logic [2:0] REG_KP       = 3'd3;
   localparam logic [2:0] REG_KI       = 3'd4;

   localparam logic [WIN_W-1:0]  RST_WIN_LOW  = 32'd10000;
   localparam logic [WIN_W-1:0]  RST_WIN_HIGH = 32'd40000;
   localparam logic [WIN_W-1:0]  RST_STEP     = 32'd20000;
   localparam logic [GAIN_W-1:0] RST_KP       = 17'd26214;
   localparam logic [GAIN_W-1:0] RST_KI       = 17'd6554;

   typedef struct packed {
      logic [TS_W-1:0] t1;
      logic [TS_W-1:0] t2;
      logic [TS_W-1:0] t3;
      logic [TS_W-1:0] t4;
      logic            last;
   } sample_type;

   typedef struct packed {
      logic [DATA_W-1:0] offset;
      logic [DATA_W-1:0] delay;
      logic [DATA_W-1:0] ms;
      logic [DATA_W-1:0] sm;
   } chosen_type;

   typedef struct packed {
      logic [WIN_W-1:0]  win_low;
      logic [WIN_W-1:0]  win_high;
      logic [WIN_W-1:0]  step_thresh;
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
   } cfg_type;

endpackage

[hdl/ptpmd_csr.sv]
`timescale 1ns / 1ps
module ptpmd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptpmd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptpmd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptpmd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output ptpmd_pkg::cfg_type                  cfg
);
   import ptpmd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_WIN_LOW:  cfg_in.win_low     = csr_pwdata[WIN_W-1:0];
            REG_WIN_HIGH: cfg_in.win_high    = csr_pwdata[WIN_W-1:0];
            REG_STEP:     cfg_in.step_thresh = csr_pwdata[WIN_W-1:0];
            REG_KP:       cfg_in.kp          = csr_pwdata[GAIN_W-1:0];
            REG_KI:       cfg_in.ki          = csr_pwdata[GAIN_W-1:0];
            default:      cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_low     <= RST_WIN_LOW;
         cfg_ff.win_high    <= RST_WIN_HIGH;
         cfg_ff.step_thresh <= RST_STEP;
         cfg_ff.kp          <= RST_KP;
         cfg_ff.ki          <= RST_KI;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_WIN_LOW:  csr_prdata = cfg_ff.win_low;
         REG_WIN_HIGH: csr_prdata = cfg_ff.win_high;
         REG_STEP:     csr_prdata = cfg_ff.step_thresh;
         REG_KP:       csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.kp};
         REG_KI:       csr_prdata = {{(CSR_DATA_W-GAIN_W){1'b0}}, cfg_ff.ki};
         default:      csr_prdata = '0;
      endcase
   end

endmodule

[hdl/ptpmd_skid.sv]
`timescale 1ns / 1ps
module ptpmd_skid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ptpmd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   input  logic                                adv,
   output logic                                s0_valid,
   output ptpmd_pkg::sample_type               s0_sample
);
   import ptpmd_pkg::*;

   sample_type in_sample;
   sample_type skid_ff;
   sample_type s0_ff;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   logic       s0_valid_ff;
   logic       s0_valid_in;
   logic       accept;

   assign in_sample.t1   = req_tdata[TS_W-1:0];
   assign in_sample.t2   = req_tdata[2*TS_W-1:TS_W];
   assign in_sample.t3   = req_tdata[3*TS_W-1:2*TS_W];
   assign in_sample.t4   = req_tdata[4*TS_W-1:3*TS_W];
   assign in_sample.last = req_tlast;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && !skid_valid_ff;
   assign s0_valid   = s0_valid_ff;
   assign s0_sample  = s0_ff;

   assign s0_valid_in   = adv ? (skid_valid_ff || accept) : s0_valid_ff;
   assign skid_valid_in = adv ? 1'b0 : (skid_valid_ff || accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff   <= s0_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= skid_valid_ff ? skid_ff : in_sample;
      end
      if (accept && !adv) begin
         skid_ff <= in_sample;
      end
   end

endmodule

[hdl/ptpmd_filter.sv]
`timescale 1ns / 1ps
module ptpmd_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   s0_valid,
   input  ptpmd_pkg::sample_type  s0_sample,
   output logic                   s4_valid,
   output logic                   s4_last,
   output ptpmd_pkg::chosen_type  s4_chosen
);
   import ptpmd_pkg::*;

   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic [DATA_W-1:0] s1_ms_ff, s1_sm_ff;
   logic [DATA_W-1:0] s2_ms_ff, s2_sm_ff, s2_sum_ff, s2_dif_ff;
   chosen_type        s3_ff;
   chosen_type        s4_ff;
   chosen_type        best_ff;
   chosen_type        best_in;
   chosen_type        next_best;
   chosen_type        reload;
   logic              hit;

   function automatic logic [DATA_W-1:0] halve(input logic [DATA_W-1:0] x);
      halve = {x[DATA_W-1], x[DATA_W-1:1]} + {{(DATA_W-1){1'b0}}, x[DATA_W-1] & x[0]};
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ms_ff   <= {1'b0, s0_sample.t2} - {1'b0, s0_sample.t1};
         s1_sm_ff   <= {1'b0, s0_sample.t4} - {1'b0, s0_sample.t3};
         s1_last_ff <= s0_sample.last;
         s2_ms_ff   <= s1_ms_ff;
         s2_sm_ff   <= s1_sm_ff;
         s2_sum_ff  <= s1_ms_ff + s1_sm_ff;
         s2_dif_ff  <= s1_ms_ff - s1_sm_ff;
         s2_last_ff <= s1_last_ff;
         s3_ff.ms     <= s2_ms_ff;
         s3_ff.sm     <= s2_sm_ff;
         s3_ff.delay  <= halve(s2_sum_ff);
         s3_ff.offset <= halve(s2_dif_ff);
         s3_last_ff   <= s2_last_ff;
         s4_ff      <= next_best;
         s4_last_ff <= s3_last_ff;
      end
   end

   always_comb begin
      reload.offset = NO_SAMPLE;
      reload.delay  = NO_SAMPLE;
      reload.ms     = '0;
      reload.sm     = '0;
      hit = !s3_ff.delay[DATA_W-1] && (s3_ff.delay != '0)
            && ($signed(s3_ff.delay) < $signed(best_ff.delay));
      next_best = hit ? s3_ff : best_ff;
      best_in   = best_ff;
      if (adv && s3_valid_ff) begin
         best_in = s3_last_ff ? reload : next_best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         best_ff       <= reload;
      end else begin
         best_ff <= best_in;
         if (adv) begin
            s1_valid_ff <= s0_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   assign s4_valid  = s4_valid_ff;
   assign s4_last   = s4_last_ff;
   assign s4_chosen = s4_ff;

endmodule

[hdl/ptpmd_servo.sv]
`timescale 1ns / 1ps
module ptpmd_servo (
   input  logic                               clock,
   input  logic                               reset,
   input  ptpmd_pkg::cfg_type                 cfg,
   input  logic                               s4_valid,
   input  logic                               s4_last,
   input  ptpmd_pkg::chosen_type              s4_chosen,
   output logic                               adv,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptpmd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                         rsp_tuser
);
   import ptpmd_pkg::*;

   typedef struct packed {
      chosen_type        chosen;
      logic [1:0]        kind;
      logic [DATA_W-1:0] step_corr;
      logic              last;
   } meta_type;

   logic              s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;
   chosen_type        s5_chosen_ff;
   logic              s5_last_ff, s5_in_win_ff;
   logic [DATA_W-1:0] s5_mag_ff, s5_neg_ff;
   meta_type          s6_ff, s7_ff, s8_ff, s9_ff;
   meta_type          s6_in;
   logic [DATA_W-1:0] s6_acc_ff;
   logic [DATA_W/2+GAIN_W:0]   s7_phi_ff, s7_qhi_ff;
   logic [DATA_W/2+GAIN_W-1:0] s7_plo_ff, s7_qlo_ff;
   logic [PROD_W-1:0] s8_sum_ff, s9_mag_ff;
   logic              s9_neg_ff;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] corr_ff, corr_in;
   meta_type          rsp_ff;
   logic              in_win, step;
   logic [DATA_W-1:0] gain_q, gain_corr;

   assign adv = !rsp_valid_ff || rsp_tready;

   assign in_win = ($signed(s4_chosen.delay) > $signed({32'd0, cfg.win_low}))
                   && ($signed(s4_chosen.delay) < $signed({32'd0, cfg.win_high}));

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_chosen_ff <= s4_chosen;
         s5_last_ff   <= s4_last;
         s5_in_win_ff <= in_win;
         s5_neg_ff    <= -s4_chosen.offset;
         s5_mag_ff    <= s4_chosen.offset[DATA_W-1] ? -s4_chosen.offset : s4_chosen.offset;
      end
   end

   always_comb begin
      step = s5_in_win_ff && (s5_mag_ff > {32'd0, cfg.step_thresh});
      s6_in.chosen    = s5_chosen_ff;
      s6_in.step_corr = s5_neg_ff;
      s6_in.last      = s5_last_ff;
      if (!s5_in_win_ff) begin
         s6_in.kind = KIND_NONE;
      end else if (step) begin
         s6_in.kind = KIND_STEP;
      end else begin
         s6_in.kind = KIND_GAIN;
      end
      acc_in = acc_ff;
      if (adv && s5_valid_ff && s5_last_ff) begin
         if (step) begin
            acc_in = '0;
         end else if (s5_in_win_ff) begin
            acc_in = acc_ff + s5_chosen_ff.offset;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_ff     <= s6_in;
         s6_acc_ff <= acc_in;
         s7_ff     <= s6_ff;
         s7_phi_ff <= $signed(s6_ff.chosen.offset[DATA_W-1:DATA_W/2])
                      * $signed({1'b0, cfg.kp});
         s7_plo_ff <= s6_ff.chosen.offset[DATA_W/2-1:0] * cfg.kp;
         s7_qhi_ff <= $signed(s6_acc_ff[DATA_W-1:DATA_W/2]) * $signed({1'b0, cfg.ki});
         s7_qlo_ff <= s6_acc_ff[DATA_W/2-1:0] * cfg.ki;
         s8_ff     <= s7_ff;
         s8_sum_ff <= {s7_phi_ff, {(DATA_W/2){1'b0}}} + {s7_qhi_ff, {(DATA_W/2){1'b0}}}
                      + {{(PROD_W-DATA_W/2-GAIN_W){1'b0}}, s7_plo_ff}
                      + {{(PROD_W-DATA_W/2-GAIN_W){1'b0}}, s7_qlo_ff};
         s9_ff     <= s8_ff;
         s9_neg_ff <= s8_sum_ff[PROD_W-1];
         s9_mag_ff <= s8_sum_ff[PROD_W-1] ? -s8_sum_ff : s8_sum_ff;
         rsp_ff    <= s9_ff;
         corr_ff   <= corr_in;
      end
   end

   assign gain_q    = DATA_W'(s9_mag_ff >> GAIN_FRAC);
   assign gain_corr = s9_neg_ff ? gain_q : -gain_q;

   always_comb begin
      unique case (s9_ff.kind)
         KIND_STEP: corr_in = s9_ff.step_corr;
         KIND_GAIN: corr_in = gain_corr;
         default:   corr_in = '0;
      endcase
   end

   assign rsp_valid_in = adv ? (s9_valid_ff && s9_ff.last) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         if (adv) begin
            s5_valid_ff <= s4_valid;
            s6_valid_ff <= s5_valid_ff;
            s7_valid_ff <= s6_valid_ff;
            s8_valid_ff <= s7_valid_ff;
            s9_valid_ff <= s8_valid_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {rsp_ff.chosen.sm, rsp_ff.chosen.ms, rsp_ff.chosen.delay,
                        rsp_ff.chosen.offset, corr_ff};

`ifndef SYNTHESIS
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.kind == KIND_NONE) |-> (corr_ff == '0))
      else $error("no-correction result carries nonzero adjustment");

   a_step_clears: assert property (@(posedge clock) disable iff (reset)
      adv && s5_valid_ff && s5_last_ff && step |=> (acc_ff == '0))
      else $error("accumulator not cleared after step");

   a_kind_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.kind != KIND_NONE)
      |-> ($signed(rsp_ff.chosen.delay) > $signed({32'd0, cfg.win_low}))
          && ($signed(rsp_ff.chosen.delay) < $signed({32'd0, cfg.win_high})))
      else $error("correction issued for delay outside window");
`endif

endmodule

[hdl/ptp_min_delay_offset_servo_core.sv]
`timescale 1ns / 1ps
// Only an item marked tlast gives a result, once it reaches the output register.
// Throughput: one item per cycle while no result is held, set by the 11-stage pipeline that advances as one.
// The whole pipeline holds while a result waits on rsp_tready; a one-item input
// skid register keeps req_tready registered.
// Reset (synchronous, active high) clears valid flags, round state and accumulator, and loads CSR defaults.
module ptp_min_delay_offset_servo_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // t1 [62:0], t2 [125:63], t3 [188:126], t4 [251:189], zero fill
   input  logic [ptpmd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // correction [63:0], offset [127:64], delay [191:128], ms [255:192], sm [319:256]
   output logic [ptpmd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // correction kind [1:0]
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptpmd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ptpmd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ptpmd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import ptpmd_pkg::*;

   cfg_type    cfg;
   logic       adv;
   logic       s0_valid;
   sample_type s0_sample;
   logic       s4_valid;
   logic       s4_last;
   chosen_type s4_chosen;

   ptpmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ptpmd_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .adv        (adv),
      .s0_valid   (s0_valid),
      .s0_sample  (s0_sample)
   );

   ptpmd_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .s0_valid  (s0_valid),
      .s0_sample (s0_sample),
      .s4_valid  (s4_valid),
      .s4_last   (s4_last),
      .s4_chosen (s4_chosen)
   );

   ptpmd_servo u_servo (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .s4_valid   (s4_valid),
      .s4_last    (s4_last),
      .s4_chosen  (s4_chosen),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
